>>> rtl/sst_pkg.sv
// Shared types and constants for the sorted set table.
// Used by the channel interfaces, the storage cell and the top level.
package sst_pkg;

   localparam int CAPACITY = 16;
   localparam int VALUE_W  = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int TOTAL_W  = 5;
   localparam int STATUS_W = 3;
   localparam int KIND_W   = 2;

   localparam logic [VALUE_W-1:0] EMPTY_MARK = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] SIGN_FLIP  = 32'h8000_0000;
   // The empty marker with its sign bit flipped; it sorts after every key.
   localparam logic [VALUE_W-1:0] KEY_MARK   = EMPTY_MARK ^ SIGN_FLIP;

   typedef enum logic [KIND_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_TEST   = 2'd2,
      REQ_CLEAR  = 2'd3
   } sst_req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE     = 3'd0,
      STATUS_PRESENT  = 3'd1,
      STATUS_ABSENT   = 3'd2,
      STATUS_FULL     = 3'd3,
      STATUS_RESERVED = 3'd4
   } sst_status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_CLEAR
   } sst_cell_op_type;

   typedef struct packed {
      sst_cell_op_type     op;
      logic [VALUE_W-1:0]  key;
   } sst_cell_cmd_type;

endpackage

>>> rtl/sst_chan_if.sv
// Valid/ready channel interfaces for the sorted set table requests and results.
// Depends on sst_pkg for field widths.
interface sst_req_if import sst_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [KIND_W-1:0]          req_type;
   logic signed [VALUE_W-1:0]  value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface sst_rsp_if import sst_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [STATUS_W-1:0]  status;
   logic [TOTAL_W-1:0]   entry_total;
   logic                 is_empty;
   logic                 is_full;

   modport source (output valid, output hit, output status, output entry_total,
                   output is_empty, output is_full, input ready);
   modport sink   (input valid, input hit, input status, input entry_total,
                   input is_empty, input is_full, output ready);
endinterface

>>> rtl/sst_cell.sv
// One slot of the sorted set chain: holds a sign-flipped key and shifts
// with its neighbors on insert and remove. Depends on sst_pkg.
module sst_cell import sst_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  sst_cell_cmd_type    cmd,
   input  logic                left_lt,
   input  logic [VALUE_W-1:0]  left_value,
   input  logic [VALUE_W-1:0]  right_value,
   output logic [VALUE_W-1:0]  value,
   output logic                lt,
   output logic                eq
);

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;

   // Empty slots hold the marker, which is never below a legal key.
   assign lt    = value_ff < cmd.key;
   assign eq    = value_ff == cmd.key;
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      case (cmd.op)
         CELL_INSERT: begin
            // The first slot not below the key takes it; slots above take
            // their left neighbor.
            if (!lt) begin
               value_in = left_lt ? cmd.key : left_value;
            end
         end
         CELL_REMOVE: begin
            if (!lt) begin
               value_in = right_value;
            end
         end
         CELL_CLEAR: value_in = KEY_MARK;
         default:    value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= KEY_MARK;
      end else begin
         value_ff <= value_in;
      end
   end

endmodule

>>> rtl/sorted_set_table.sv
// Sorted set table: keeps up to CAPACITY distinct signed 32-bit values in
// ascending order in a row of storage cells.
// The request channel (req_ch) carries a kind (insert, remove, membership
// test, clear) and a value. Each request produces exactly one result on
// rsp_ch with hit, status, the entry count after the request, and the
// empty and full flags.
// Every cell compares its entry with the request value at once and shifts
// with its neighbor, so a request completes in the cycle it is accepted and
// its result is valid in the next cycle. One request per cycle is sustained
// while results are taken, as the whole row compares and shifts at once.
// The result sits in an output register; a new request is taken whenever
// that register is empty or its result is being taken in the same cycle.
// While the receiver stalls, the result holds and requests wait.
// Reset is synchronous and active high: every cell returns to the empty
// marker, the count to zero and the result register to empty. No clearing
// pass is needed.
// The value 0x7FFFFFFF is reserved as the empty marker and is never stored.
module sorted_set_table import sst_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sst_req_if.sink    req_ch,
   sst_rsp_if.source  rsp_ch
);

   logic                  accept;
   logic [VALUE_W-1:0]    key;
   logic                  reserved;
   logic                  present;
   logic                  full;
   logic [CAPACITY-1:0]   lt_vec;
   logic [CAPACITY-1:0]   eq_vec;
   logic [VALUE_W-1:0]    cell_value [CAPACITY];
   sst_cell_cmd_type      cmd;
   sst_cell_op_type       op;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  hit;
   sst_status_type        status;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  hit_ff;
   logic [STATUS_W-1:0]   status_ff;
   logic [TOTAL_W-1:0]    total_ff;
   logic                  empty_ff;
   logic                  full_ff;

   assign req_ch.ready = !reset && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   assign key      = req_ch.value ^ SIGN_FLIP;
   assign reserved = req_ch.value == EMPTY_MARK;
   assign present  = |eq_vec;
   assign full     = count_ff == CNT_W'(CAPACITY);

   assign cmd.op  = accept ? op : CELL_HOLD;
   assign cmd.key = key;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                left_lt;
      logic [VALUE_W-1:0]  left_value;
      logic [VALUE_W-1:0]  right_value;

      if (i == 0) begin : g_first
         // The first cell behaves as if its missing neighbor were below every key.
         assign left_lt    = 1'b1;
         assign left_value = KEY_MARK;
      end else begin : g_inner
         assign left_lt    = lt_vec[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = KEY_MARK;
      end else begin : g_body
         assign right_value = cell_value[i+1];
      end

      sst_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_lt     (left_lt),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[i]),
         .lt          (lt_vec[i]),
         .eq          (eq_vec[i])
      );
   end

   always_comb begin
      op       = CELL_HOLD;
      count_in = count_ff;
      hit      = 1'b0;
      status   = STATUS_DONE;
      case (sst_req_kind_type'(req_ch.req_type))
         REQ_CLEAR: begin
            op       = CELL_CLEAR;
            count_in = '0;
         end
         REQ_TEST: begin
            if (reserved || !present) begin
               status = STATUS_ABSENT;
            end else begin
               hit = 1'b1;
            end
         end
         REQ_INSERT: begin
            if (reserved) begin
               status = STATUS_RESERVED;
            end else if (present) begin
               status = STATUS_PRESENT;
            end else if (full) begin
               status = STATUS_FULL;
            end else begin
               op       = CELL_INSERT;
               count_in = count_ff + CNT_W'(1);
               hit      = 1'b1;
            end
         end
         REQ_REMOVE: begin
            if (reserved) begin
               status = STATUS_RESERVED;
            end else if (present) begin
               op       = CELL_REMOVE;
               count_in = count_ff - CNT_W'(1);
               hit      = 1'b1;
            end else begin
               status = STATUS_ABSENT;
            end
         end
         default: op = CELL_HOLD;
      endcase
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
      if (accept) begin
         hit_ff    <= hit;
         status_ff <= status;
         total_ff  <= TOTAL_W'(count_in);
         empty_ff  <= count_in == '0;
         full_ff   <= count_in == CNT_W'(CAPACITY);
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.hit         = hit_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.entry_total = total_ff;
   assign rsp_ch.is_empty    = empty_ff;
   assign rsp_ch.is_full     = full_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_first_slot: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == (cell_value[0] == KEY_MARK))
      else $error("first slot disagrees with entry count");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no result");

   a_hit_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && hit_ff) |-> (status_ff == STATUS_DONE))
      else $error("hit reported with a failure status");
`endif

endmodule

>>> sim/sorted_set_checker.sv
`timescale 1ns / 100ps
// Result checker for the sorted set table: watches both channels, keeps its own
// copy of the ordered set and compares every result. Depends on sst_pkg.
module sorted_set_checker import sst_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [KIND_W-1:0]          req_type,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       rsp_hit,
   input  logic [STATUS_W-1:0]        rsp_status,
   input  logic [TOTAL_W-1:0]         rsp_entry_total,
   input  logic                       rsp_is_empty,
   input  logic                       rsp_is_full,
   output int                         mismatch_total,
   output int                         awaited_total,
   output int                         answers_seen,
   output int                         full_refusals
);

   typedef struct packed {
      logic                hit;
      sst_status_type      status;
      logic [TOTAL_W-1:0]  total;
      logic                empty;
      logic                full;
   } set_answer_type;

   logic signed [VALUE_W-1:0] held_vals [CAPACITY];
   int                        held_total = 0;
   set_answer_type            pending_answers [$];
   int                        errs = 0;
   int                        seen = 0;
   int                        refusals = 0;

   // Applies one request to the shadow set and works out the answer it earns.
   task automatic predict_answer(input sst_req_kind_type kind,
                                 input logic signed [VALUE_W-1:0] val,
                                 output set_answer_type ans);
      int pos;
      bit present;
      pos = 0;
      while (pos < held_total && held_vals[pos] < val)
         pos++;
      present = (pos < held_total) && (held_vals[pos] == val);
      ans.hit    = 1'b0;
      ans.status = STATUS_DONE;
      if (kind == REQ_CLEAR) begin
         held_total = 0;
      end else if (val == EMPTY_MARK) begin
         // The empty marker is never stored; a test simply reports it absent.
         ans.status = (kind == REQ_TEST) ? STATUS_ABSENT : STATUS_RESERVED;
      end else begin
         case (kind)
            REQ_INSERT: begin
               if (present) begin
                  ans.status = STATUS_PRESENT;
               end else if (held_total >= CAPACITY) begin
                  ans.status = STATUS_FULL;
               end else begin
                  for (int j = held_total; j > pos; j--)
                     held_vals[j] = held_vals[j-1];
                  held_vals[pos] = val;
                  held_total++;
                  ans.hit = 1'b1;
               end
            end
            REQ_REMOVE: begin
               if (present) begin
                  for (int j = pos; j + 1 < held_total; j++)
                     held_vals[j] = held_vals[j+1];
                  held_total--;
                  ans.hit = 1'b1;
               end else begin
                  ans.status = STATUS_ABSENT;
               end
            end
            default: begin
               if (present)
                  ans.hit = 1'b1;
               else
                  ans.status = STATUS_ABSENT;
            end
         endcase
      end
      ans.total = held_total[TOTAL_W-1:0];
      ans.empty = (held_total == 0);
      ans.full  = (held_total == CAPACITY);
   endtask

   task automatic report_field(input string field, input int want, input logic [7:0] got);
      if (got !== want[7:0]) begin
         errs++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      set_answer_type want;
      set_answer_type fresh;
      if (reset) begin
         held_total = 0;
         pending_answers.delete();
      end else begin
         // A result can never belong to the request taken at the same edge.
         if (rsp_valid && rsp_ready) begin
            seen++;
            if (pending_answers.size() == 0) begin
               errs++;
               $display("%0t: result arrived with no request waiting, expected none, actual %b",
                        $time, {rsp_hit, rsp_status, rsp_entry_total, rsp_is_empty, rsp_is_full});
            end else begin
               want = pending_answers.pop_front();
               if (want.status == STATUS_FULL)
                  refusals++;
               report_field("hit", want.hit, rsp_hit);
               report_field("status", want.status, rsp_status);
               report_field("entry_total", want.total, rsp_entry_total);
               report_field("is_empty", want.empty, rsp_is_empty);
               report_field("is_full", want.full, rsp_is_full);
            end
         end
         if (req_valid && req_ready) begin
            predict_answer(sst_req_kind_type'(req_type), req_value, fresh);
            pending_answers.push_back(fresh);
         end
      end
      mismatch_total <= errs;
      awaited_total  <= pending_answers.size();
      answers_seen   <= seen;
      full_refusals  <= refusals;
   end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Top of the sorted set table testbench: clock, reset, request stimulus and
// result back-pressure. Depends on sst_pkg, the channel interfaces and the checker.
module tb_top;
   import sst_pkg::*;

   localparam int PHASES          = 4;
   localparam int PHASE_REQUESTS  = 500;
   localparam int POOL_SIZE       = 24;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   sst_req_if req_bus ();
   sst_rsp_if rsp_bus ();

   sorted_set_table u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   int mismatch_total;
   int awaited_total;
   int answers_seen;
   int full_refusals;

   sorted_set_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_type        (req_bus.req_type),
      .req_value       (req_bus.value),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_hit         (rsp_bus.hit),
      .rsp_status      (rsp_bus.status),
      .rsp_entry_total (rsp_bus.entry_total),
      .rsp_is_empty    (rsp_bus.is_empty),
      .rsp_is_full     (rsp_bus.is_full),
      .mismatch_total  (mismatch_total),
      .awaited_total   (awaited_total),
      .answers_seen    (answers_seen),
      .full_refusals   (full_refusals)
   );

   bit          send_idle = 1'b0;
   bit          take_idle = 1'b0;
   int          stall_left = 0;
   int          kinds_sent [4];
   logic [31:0] value_pool [POOL_SIZE];

   // Result back-pressure: ready drops in random bursts while stalls are enabled.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (take_idle && $urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(1, 16) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Called at a falling edge; returns at the falling edge after the handshake
   // with valid still high, so back-to-back requests need no second assignment.
   task automatic send_request(input sst_req_kind_type kind, input logic [31:0] val);
      if (send_idle && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.value    <= val;
      do
         @(posedge clock);
      while (!(req_bus.valid && req_bus.ready));
      kinds_sent[int'(kind)]++;
      @(negedge clock);
   endtask

   function automatic sst_req_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 42)
         return REQ_INSERT;
      else if (r < 67)
         return REQ_REMOVE;
      else if (r < 97)
         return REQ_TEST;
      else
         return REQ_CLEAR;
   endfunction

   // Mostly values from a small pool, so duplicates, hits and a full set are common.
   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return value_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (r < 90)
         return $urandom;
      case ($urandom_range(0, 4))
         0:       return EMPTY_MARK;
         1:       return 32'h8000_0000;
         2:       return 32'h7FFF_FFFE;
         3:       return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   initial begin
      #5_000_000;
      $display("[sorted_set_table] ERROR");
      $finish;
   end

   initial begin
      req_bus.valid    = 1'b0;
      req_bus.req_type = REQ_INSERT;
      req_bus.value    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle = 1'b1;
      take_idle = 1'b1;

      // Directed opening: empty set, extremes, the reserved value, a full set.
      send_request(REQ_TEST, 32'd5);
      send_request(REQ_REMOVE, 32'd5);
      send_request(REQ_INSERT, 32'h8000_0000);
      send_request(REQ_INSERT, 32'h7FFF_FFFE);
      send_request(REQ_INSERT, 32'h0000_0000);
      send_request(REQ_INSERT, 32'hFFFF_FFFF);
      send_request(REQ_INSERT, 32'h0000_0000);
      send_request(REQ_INSERT, EMPTY_MARK);
      send_request(REQ_REMOVE, EMPTY_MARK);
      send_request(REQ_TEST, EMPTY_MARK);
      send_request(REQ_TEST, 32'h8000_0000);
      for (int i = 1; i <= 12; i++)
         send_request(REQ_INSERT, i * 1000 + 1);
      send_request(REQ_INSERT, 32'd7);
      send_request(REQ_INSERT, 32'h0000_0000);
      send_request(REQ_REMOVE, 32'hFFFF_FFFF);
      send_request(REQ_REMOVE, 32'hFFFF_FFFF);
      send_request(REQ_CLEAR, 32'hFFFF_FFFF);

      for (int phase = 0; phase < PHASES; phase++) begin
         for (int i = 0; i < POOL_SIZE; i++)
            value_pool[i] = (i % 3 == 0) ? $urandom_range(0, 40) - 20 : $urandom;
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            // Stall patterns change every few dozen requests; the last phase runs flat out.
            if (n % 50 == 0) begin
               send_idle = (phase < PHASES - 1) && ($urandom_range(0, 2) != 0);
               take_idle = (phase < PHASES - 1) && ($urandom_range(0, 2) != 0);
            end
            send_request(pick_kind(), pick_value());
         end
      end
      req_bus.valid <= 1'b0;

      wait (awaited_total == 0);
      repeat (4) @(posedge clock);

      $display("Sent %0d inserts, %0d removes, %0d membership tests and %0d clears.",
               kinds_sent[REQ_INSERT], kinds_sent[REQ_REMOVE], kinds_sent[REQ_TEST],
               kinds_sent[REQ_CLEAR]);
      $display("Checked %0d results, %0d of them refused for a full set; %0d mismatches.",
               answers_seen, full_refusals, mismatch_total);
      if (mismatch_total == 0 && awaited_total == 0) begin
         $display("[sorted_set_table] OK");
      end else begin
         $display("[sorted_set_table] ERROR");
      end
      $finish;
   end

endmodule
